// ----- hdl/blie_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded integer list engine package
// Field widths, operation and status codes, and the cell update modes.
// ----------------------------------------------------------------------------
package blie_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned SIZE_W   = 5;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REM_VALUE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // How every cell updates its entry in the apply cycle.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_INS_FRONT,
    SH_INS_BACK,
    SH_DROP
  } blie_shift_e;

endpackage

// ----- hdl/blie_in_if.sv -----
// ----------------------------------------------------------------------------
// Bounded integer list engine request channel
// Valid/ready channel that carries one operation and its operand.
// ----------------------------------------------------------------------------
interface blie_in_if;
  logic                                valid;
  logic                                ready;
  logic [blie_pkg::KIND_W-1:0]         kind;
  logic signed [blie_pkg::VAL_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- hdl/blie_out_if.sv -----
// ----------------------------------------------------------------------------
// Bounded integer list engine result channel
// Valid/ready channel that carries one result per operation.
// ----------------------------------------------------------------------------
interface blie_out_if;
  logic                                valid;
  logic                                ready;
  logic [blie_pkg::STATUS_W-1:0]       status;
  logic signed [blie_pkg::VAL_W-1:0]   removed_value;
  logic                                found;
  logic [blie_pkg::POS_W-1:0]          position;
  logic [blie_pkg::OCC_W-1:0]          occurrences;
  logic [blie_pkg::SIZE_W-1:0]         size;
  logic signed [blie_pkg::VAL_W-1:0]   front_value;
  logic signed [blie_pkg::VAL_W-1:0]   back_value;
  logic                                nonempty;

  modport source (output valid, output status, output removed_value, output found,
                  output position, output occurrences, output size,
                  output front_value, output back_value, output nonempty,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input found,
                  input position, input occurrences, input size,
                  input front_value, input back_value, input nonempty,
                  output ready);
endinterface

// ----- hdl/blie_cell.sv -----
// ----------------------------------------------------------------------------
// Bounded integer list engine cell
// Holds one list entry, adds its compare result to the passing scan token,
// and on update shifts entries to or from its neighbors or loads the operand.
// ----------------------------------------------------------------------------
module blie_cell #(
  parameter int unsigned DEPTH = blie_pkg::DEPTH_DEF,
  parameter int unsigned IDX   = 0,
  parameter type         ctl_t = logic,
  parameter type         tok_t = logic
) (
  input  logic                        clk_i,
  input  ctl_t                        ctl_i,
  input  logic [blie_pkg::VAL_W-1:0]  left_i,
  input  logic [blie_pkg::VAL_W-1:0]  right_i,
  output logic [blie_pkg::VAL_W-1:0]  entry_o,
  input  tok_t                        tok_i,
  output tok_t                        tok_o
);
  import blie_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);
  localparam logic [CW:0]   IDX_P1   = (CW + 1)'(IDX + 1);
  localparam logic [CW:0]   IDX_P2   = (CW + 1)'(IDX + 2);

  logic [VAL_W-1:0] entry_q, entry_d;
  tok_t             tok_q, tok_d;
  logic             live;
  logic             hit;

  // The token picks up the first match, the match count and the last two
  // live entries as it walks from the front of the list to the back.
  always_comb begin
    live  = MY_IDX_C < ctl_i.cnt;
    hit   = live && (entry_q == ctl_i.value);
    tok_d = tok_i;
    if (hit && !tok_i.found) begin
      tok_d.found = 1'b1;
      tok_d.pos   = MY_IDX;
    end
    if (hit) begin
      tok_d.occ = tok_i.occ + CW'(1);
    end
    if ({1'b0, ctl_i.cnt} == IDX_P1) begin
      tok_d.last1 = entry_q;
    end
    if ({1'b0, ctl_i.cnt} == IDX_P2) begin
      tok_d.last2 = entry_q;
    end
  end

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.shift)
      SH_INS_FRONT: entry_d = left_i;
      SH_INS_BACK: begin
        if (ctl_i.cnt == MY_IDX_C) entry_d = ctl_i.value;
      end
      SH_DROP: begin
        if (MY_IDX >= ctl_i.pos) entry_d = right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tok_q   <= tok_d;
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;

endmodule

// ----- hdl/bounded_integer_list_engine.sv -----
// ----------------------------------------------------------------------------
// Bounded integer list engine
// Ordered double-ended list of up to DEPTH signed words with insert, remove,
// remove by value, search, count and clear, built as a row of entry cells.
// ----------------------------------------------------------------------------
// A request is taken only in the idle state, so one operation is in flight
// at a time; the scan token must walk the whole cell row before the list
// may change.
// The request and result sides are decoupled by the result register, so a
// new request is taken while the previous result still waits.
// Reset clears the fill count, the controller and the result valid; the
// entry cells are not reset and are only read below the fill count.
module bounded_integer_list_engine #(
  parameter int unsigned DEPTH = blie_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blie_in_if.sink    in_i,
  blie_out_if.source out_o
);
  import blie_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
  localparam logic [IW-1:0] SCAN_LAST = IW'(DEPTH - 1);

  // Controller states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Broadcast to every cell.
  typedef struct packed {
    blie_shift_e       shift;
    logic [IW-1:0]     pos;
    logic [CW-1:0]     cnt;
    logic [VAL_W-1:0]  value;
  } ctl_t;

  // Scan token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              found;
    logic [IW-1:0]     pos;
    logic [CW-1:0]     occ;
    logic [VAL_W-1:0]  last1;
    logic [VAL_W-1:0]  last2;
  } tok_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    removed;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occ;
    logic [SIZE_W-1:0]   size;
    logic [VAL_W-1:0]    front;
    logic [VAL_W-1:0]    back;
    logic                nonempty;
  } res_t;

  logic [1:0]        state_q, state_d;
  logic [IW-1:0]     scan_q, scan_d;
  logic [KIND_W-1:0] kind_q;
  logic [VAL_W-1:0]  op_value_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q;
  logic              in_xfer;
  logic              out_load;

  ctl_t              ctl;
  blie_shift_e       shift_sel;
  logic [IW-1:0]     drop_pos;
  tok_t              tk;

  logic [VAL_W-1:0]  entry   [DEPTH];
  logic [VAL_W-1:0]  left_w  [DEPTH];
  logic [VAL_W-1:0]  right_w [DEPTH];
  tok_t              tok     [DEPTH+1];

  // --------------------------------------------------------------------------
  // Cell row. Cell 0 is the front of the list. The token enters at the front
  // empty and leaves the back cell holding the search, count and tail data.
  // --------------------------------------------------------------------------
  assign tok[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign left_w[g] = op_value_q;
    end else begin : g_mid
      assign left_w[g] = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign right_w[g] = entry[g];
    end else begin : g_inner
      assign right_w[g] = entry[g+1];
    end

    blie_cell #(
      .DEPTH (DEPTH),
      .IDX   (g),
      .ctl_t (ctl_t),
      .tok_t (tok_t)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .entry_o (entry[g]),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  assign tk = tok[DEPTH];

  assign ctl.shift = (state_q == S_APPLY) ? shift_sel : SH_NONE;
  assign ctl.pos   = drop_pos;
  assign ctl.cnt   = cnt_q;
  assign ctl.value = op_value_q;

  // --------------------------------------------------------------------------
  // Operation decode, evaluated in the apply cycle once the token has left
  // the back cell. The front value is read after the update, in the done
  // state, from cell 0.
  // --------------------------------------------------------------------------
  always_comb begin
    logic          is_full;
    logic          is_empty;
    logic [CW-1:0] last_idx;
    logic [VAL_W-1:0] back_v;

    is_full   = cnt_q == CNT_FULL;
    is_empty  = cnt_q == '0;
    last_idx  = cnt_q - CW'(1);
    back_v    = tk.last1;
    cnt_d     = cnt_q;
    shift_sel = SH_NONE;
    drop_pos  = '0;
    res_d     = '0;
    res_d.status = ST_OK;

    case (kind_q)
      KIND_INS_FRONT: begin
        if (is_full) begin
          res_d.status = ST_FULL;
        end else begin
          shift_sel = SH_INS_FRONT;
          cnt_d     = cnt_q + CW'(1);
          if (is_empty) back_v = op_value_q;
        end
      end
      KIND_INS_BACK: begin
        if (is_full) begin
          res_d.status = ST_FULL;
        end else begin
          shift_sel = SH_INS_BACK;
          cnt_d     = cnt_q + CW'(1);
          back_v    = op_value_q;
        end
      end
      KIND_REM_FRONT: begin
        if (is_empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.removed = entry[0];
          shift_sel     = SH_DROP;
          cnt_d         = last_idx;
          // With one entry left the list empties and the back is masked.
        end
      end
      KIND_REM_BACK: begin
        if (is_empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.removed = tk.last1;
          cnt_d         = last_idx;
          back_v        = tk.last2;
        end
      end
      KIND_REM_VALUE: begin
        if (is_empty) begin
          res_d.status = ST_EMPTY;
        end else if (!tk.found) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          res_d.removed = op_value_q;
          shift_sel     = SH_DROP;
          drop_pos      = tk.pos;
          cnt_d         = last_idx;
          // Removing the tail entry moves the back one place forward.
          if (tk.pos == IW'(last_idx)) back_v = tk.last2;
        end
      end
      KIND_SEARCH: begin
        if (tk.found) begin
          res_d.found    = 1'b1;
          res_d.position = POS_W'(tk.pos);
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      KIND_COUNT: begin
        res_d.occ = OCC_W'(tk.occ);
      end
      KIND_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase

    res_d.size     = SIZE_W'(cnt_d);
    res_d.nonempty = cnt_d != '0;
    res_d.back     = res_d.nonempty ? back_v : '0;
    res_d.front    = '0;
  end

  // The output payload is the pending result with the front taken from cell 0
  // after the update.
  always_comb begin
    out_d       = res_q;
    out_d.front = res_q.nonempty ? entry[0] : '0;
  end

  // --------------------------------------------------------------------------
  // Controller.
  // --------------------------------------------------------------------------
  assign in_i.ready = state_q == S_IDLE;
  assign in_xfer    = in_i.valid && (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
          scan_d  = '0;
        end
      end
      S_SCAN: begin
        scan_d = scan_q + IW'(1);
        if (scan_q == SCAN_LAST) state_d = S_APPLY;
      end
      S_APPLY: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (state_q == S_APPLY) cnt_q <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand, pending result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q     <= in_i.kind;
      op_value_q <= in_i.value;
    end
    if (state_q == S_APPLY) res_q <= res_d;
    if (out_load) out_q <= out_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.removed_value = out_q.removed;
  assign out_o.found         = out_q.found;
  assign out_o.position      = out_q.position;
  assign out_o.occurrences   = out_q.occ;
  assign out_o.size          = out_q.size;
  assign out_o.front_value   = out_q.front;
  assign out_o.back_value    = out_q.back;
  assign out_o.nonempty      = out_q.nonempty;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("fill count above list depth");

  a_cnt_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> $stable(cnt_q))
    else $error("fill count changed outside the apply cycle");

  a_full_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_FULL)) |-> (out_o.size == SIZE_W'(DEPTH)))
    else $error("insert rejected while list not full");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.nonempty) |-> (out_o.front_value == '0 && out_o.back_value == '0))
    else $error("empty list reports nonzero front or back");

  a_start_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_SCAN && scan_q == '0))
    else $error("request transfer did not start a scan");

endmodule

// ----- verif/bounded_integer_list_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded integer list engine testbench
// Drives list operations through the request channel and checks every result
// against a queue-based model of the list. A short directed run covers the
// empty, not-found and extreme-value cases. Random fill, drain and noise
// sequences follow, with bursty requests, a patterned result stall, one long
// result hold-off and pauses that let the engine drain completely.
// ----------------------------------------------------------------------------
module bounded_integer_list_engine_tb;
  import blie_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned TARGET_OPS = 650;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // One operation waiting to be sent. A set hold bit makes the sender wait
  // until every outstanding result has come back before it offers the item.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    bit                hold;
  } list_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    removed;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occurrences;
    logic [SIZE_W-1:0]   size;
    logic [VAL_W-1:0]    front;
    logic [VAL_W-1:0]    back;
    logic                nonempty;
  } list_result_t;

  logic clk;
  logic rst_n = 1'b0;

  // Values driven onto the channels. They start known at time zero.
  logic              drv_valid = 1'b0;
  logic [KIND_W-1:0] drv_kind  = '0;
  logic [VAL_W-1:0]  drv_value = '0;
  logic              drv_ready = 1'b0;

  blie_in_if  req_if ();
  blie_out_if res_if ();

  assign req_if.valid = drv_valid;
  assign req_if.kind  = drv_kind;
  assign req_if.value = drv_value;
  assign res_if.ready = drv_ready;

  bounded_integer_list_engine #(
    .DEPTH (LIST_DEPTH)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  list_request_t     pending_ops[$];
  list_result_t      expected_results[$];
  logic [VAL_W-1:0]  list_q[$];
  logic [VAL_W-1:0]  value_pool[8];

  int unsigned ops_queued    = 0;
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  bit          req_taken     = 1'b0;

  // Sender burst state.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver stall state.
  int unsigned rx_cycles    = 0;
  int unsigned stall_mode   = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is held low from the start and released once, on a falling edge.
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Applies one operation to the model list and returns the result that the
  // engine must report for it. Search and remove-by-value look for the first
  // entry that matches bit for bit; count tallies every such entry.
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] op,
                                                 input logic [VAL_W-1:0]  operand);
    list_result_t r;
    int           hit;
    int           tally;
    r     = '0;
    hit   = -1;
    tally = 0;
    for (int k = 0; k < list_q.size(); k++) begin
      if (list_q[k] == operand) begin
        tally++;
        if (hit < 0) hit = k;
      end
    end
    r.status = ST_OK;
    case (op)
      KIND_INS_FRONT: begin
        if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
        else list_q.push_front(operand);
      end
      KIND_INS_BACK: begin
        if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
        else list_q.push_back(operand);
      end
      KIND_REM_FRONT: begin
        if (list_q.size() == 0) r.status = ST_EMPTY;
        else r.removed = list_q.pop_front();
      end
      KIND_REM_BACK: begin
        if (list_q.size() == 0) r.status = ST_EMPTY;
        else r.removed = list_q.pop_back();
      end
      KIND_REM_VALUE: begin
        if (list_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.removed = list_q[hit];
          list_q.delete(hit);
        end
      end
      KIND_SEARCH: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found    = 1'b1;
          r.position = POS_W'(hit);
        end
      end
      KIND_COUNT: begin
        r.occurrences = OCC_W'(tally);
      end
      default: begin
        list_q.delete();
      end
    endcase
    r.size = SIZE_W'(list_q.size());
    if (list_q.size() > 0) begin
      r.front    = list_q[0];
      r.back     = list_q[list_q.size()-1];
      r.nonempty = 1'b1;
    end
    return r;
  endfunction

  task automatic push_op(input logic [KIND_W-1:0] op, input logic [VAL_W-1:0] operand,
                         input bit hold);
    list_request_t item;
    item.kind  = op;
    item.value = operand;
    item.hold  = hold;
    pending_ops.push_back(item);
    ops_queued++;
  endtask

  // Most operands come from a small pool so that searches, counts and
  // removals by value actually hit; the rest are fully random or extreme.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) return value_pool[$urandom_range(0, 7)];
    if (r <= 7) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic report_field(input string name, input logic [VAL_W-1:0] exp_val,
                              input logic [VAL_W-1:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $display("%0t: result %0d field %s expected %0h actual %0h",
               $realtime, results_seen, name, exp_val, act_val);
    end
  endtask

  // Request side, sampled at the rising edge: a transfer feeds the model and
  // retires the item from the pending queue.
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (rst_n && req_if.valid && req_if.ready) begin
      expected_results.push_back(apply_list_op(req_if.kind, req_if.value));
      void'(pending_ops.pop_front());
      req_taken = 1'b1;
    end
  end

  // Result side, sampled at the rising edge: every transfer is checked field
  // by field against the oldest expectation.
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result transfer with no operation outstanding, size %0d",
                 $realtime, res_if.size);
      end else begin
        exp_res = expected_results.pop_front();
        report_field("status", VAL_W'(exp_res.status), VAL_W'(res_if.status));
        report_field("removed_value", exp_res.removed, res_if.removed_value);
        report_field("found", VAL_W'(exp_res.found), VAL_W'(res_if.found));
        report_field("position", VAL_W'(exp_res.position), VAL_W'(res_if.position));
        report_field("occurrences", VAL_W'(exp_res.occurrences),
                     VAL_W'(res_if.occurrences));
        report_field("size", VAL_W'(exp_res.size), VAL_W'(res_if.size));
        report_field("front_value", exp_res.front, res_if.front_value);
        report_field("back_value", exp_res.back, res_if.back_value);
        report_field("nonempty", VAL_W'(exp_res.nonempty), VAL_W'(res_if.nonempty));
      end
      results_seen++;
    end
  end

  // Request driver. An item that is offered stays offered until it is taken.
  // Otherwise the sender works through bursts of random length separated by
  // random gaps, some of them zero so that back-to-back stretches occur.
  always @(negedge clk) begin
    logic              next_valid;
    logic [KIND_W-1:0] next_kind;
    logic [VAL_W-1:0]  next_value;
    next_valid = drv_valid;
    next_kind  = drv_kind;
    next_value = drv_value;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!(drv_valid && !req_taken)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0 &&
                   !(pending_ops[0].hold && expected_results.size() != 0)) begin
        next_valid = 1'b1;
        next_kind  = pending_ops[0].kind;
        next_value = pending_ops[0].value;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
    end
    drv_valid <= next_valid;
    drv_kind  <= next_kind;
    drv_value <= next_value;
  end

  // Result receiver. It switches between four stall patterns as the run goes
  // on, and once it refuses results for a long stretch so that the engine
  // backs up and stops taking requests.
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      rx_cycles++;
      if (rx_cycles % 128 == 0) stall_mode = $urandom_range(0, 3);
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (!holdoff_done && rx_cycles >= 4000) begin
        holdoff_done = 1'b1;
        holdoff_left = 300;
      end else begin
        case (stall_mode)
          0:       next_ready = 1'b1;
          1:       next_ready = 1'($urandom_range(0, 1));
          2:       next_ready = (rx_cycles % 7) < 4;
          default: next_ready = $urandom_range(0, 9) != 0;
        endcase
      end
    end
    drv_ready <= next_ready;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned n;
    bit          first;
    value_pool[0] = VAL_MAX;
    value_pool[1] = VAL_MIN;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;

    // Directed part: every operation on the empty list, then extreme values,
    // duplicates, a first-match removal and a removal that finds nothing.
    push_op(KIND_REM_FRONT, '0, 1'b0);
    push_op(KIND_REM_BACK, '0, 1'b0);
    push_op(KIND_REM_VALUE, '0, 1'b0);
    push_op(KIND_SEARCH, '0, 1'b0);
    push_op(KIND_COUNT, '0, 1'b0);
    push_op(KIND_CLEAR, '0, 1'b0);
    push_op(KIND_INS_FRONT, VAL_MAX, 1'b0);
    push_op(KIND_INS_BACK, VAL_MIN, 1'b0);
    push_op(KIND_INS_FRONT, '0, 1'b0);
    push_op(KIND_INS_BACK, '1, 1'b0);
    push_op(KIND_SEARCH, VAL_MIN, 1'b0);
    push_op(KIND_COUNT, '1, 1'b0);
    push_op(KIND_INS_BACK, VAL_MAX, 1'b0);
    push_op(KIND_COUNT, VAL_MAX, 1'b0);
    push_op(KIND_REM_VALUE, VAL_MAX, 1'b0);
    push_op(KIND_SEARCH, VAL_MAX, 1'b0);
    push_op(KIND_REM_VALUE, 32'h0000_3039, 1'b0);
    push_op(KIND_REM_FRONT, '0, 1'b0);
    push_op(KIND_REM_BACK, '0, 1'b0);
    push_op(KIND_CLEAR, '0, 1'b0);

    // Random part, built from sequences. Fill sequences run the list into
    // its full limit, drain sequences empty it again, and noise mixes every
    // operation. The first random item always waits for a complete drain.
    first = 1'b1;
    while (ops_queued < TARGET_OPS) begin
      if ($urandom_range(0, 7) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(12, 20);
          for (int k = 0; k < n; k++) begin
            push_op($urandom_range(0, 1) ? KIND_INS_BACK : KIND_INS_FRONT, pick_value(),
                    first || (k == 0 && $urandom_range(0, 5) == 0));
            first = 1'b0;
          end
          n = $urandom_range(2, 6);
          for (int k = 0; k < n; k++) begin
            push_op($urandom_range(0, 1) ? KIND_SEARCH : KIND_COUNT, pick_value(), 1'b0);
          end
        end
        4, 5, 6: begin
          n = $urandom_range(6, 20);
          for (int k = 0; k < n; k++) begin
            push_op(KIND_W'($urandom_range(KIND_REM_FRONT, KIND_COUNT)), pick_value(),
                    first || (k == 0 && $urandom_range(0, 5) == 0));
            first = 1'b0;
          end
        end
        7, 8: begin
          n = $urandom_range(4, 12);
          for (int k = 0; k < n; k++) begin
            push_op(KIND_W'($urandom_range(0, 7)), $urandom, first);
            first = 1'b0;
          end
        end
        default: begin
          push_op(KIND_CLEAR, $urandom, first);
          first = 1'b0;
          n = $urandom_range(1, 5);
          for (int k = 0; k < n; k++) push_op(KIND_INS_BACK, pick_value(), 1'b0);
        end
      endcase
    end

    @(posedge rst_n);
    while (pending_ops.size() != 0 || drv_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Let a stray late result show up before the verdict.
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d operations pending, %0d results outstanding",
             pending_ops.size(), expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- bounded_integer_list_engine.f -----
hdl/blie_pkg.sv
hdl/blie_in_if.sv
hdl/blie_out_if.sv
hdl/blie_cell.sv
hdl/bounded_integer_list_engine.sv
verif/bounded_integer_list_engine_tb.sv
